### design/spj_pkg.sv
// Shared constants, types and saturation helper for the stereo projection Jacobian core.
package spj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_WORDS  = 24;
  localparam int NUM_VALUES = 16;
  localparam int DIV_STEPS  = 64;

  localparam int PROD_W = 66;

  typedef logic signed [31:0]       word_t;
  typedef logic signed [32:0]       mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [63:0]       num_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = -32'sh7FFF_FFFF - 32'sd1;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_FOCAL = 2'd0,
    REG_PU    = 2'd1,
    REG_PV    = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // Divider handshake
  typedef struct packed {
    logic  start;
    num_t  num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } div_rsp_t;

  // Clamp a wide signed value into 32 bits
  function automatic word_t sat_wide(input prod_t v);
    word_t r;
    if (v > prod_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < prod_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/spj_mul.sv
// Shared signed 33x33 multiplier with a registered product.
module spj_mul
  import spj_pkg::*;
(
  input  logic    clk,
  input  mul_op_t op_a,
  input  mul_op_t op_b,
  output prod_t   prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

### design/spj_div.sv
// Radix-2 restoring signed divider, truncating toward zero with 32-bit saturation.
module spj_div
  import spj_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] qsh;
  logic [31:0] dmag;
  logic        neg;

  logic [32:0] rem_sh;
  logic        bit_q;
  logic [31:0] rem_next;
  logic [63:0] qsh_next;
  word_t       fin;

  always_comb begin
    rem_sh = {rem, qsh[63]};
    bit_q  = (rem_sh >= {1'b0, dmag});
    rem_next = bit_q ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
    qsh_next = {qsh[62:0], bit_q};
    if (neg) begin
      fin = (qsh_next > 64'h8000_0000) ? WORD_MIN : word_t'(-qsh_next[31:0]);
    end else begin
      fin = (qsh_next > 64'h7FFF_FFFF) ? WORD_MAX : word_t'(qsh_next[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.den == 32'sd0) begin
          rsp.done <= 1'b1;
          if (req.num > 64'sd0) begin
            rsp.quo <= WORD_MAX;
          end else if (req.num < 64'sd0) begin
            rsp.quo <= WORD_MIN;
          end else begin
            rsp.quo <= 32'sd0;
          end
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          rem  <= '0;
          qsh  <= req.num[63] ? 64'(-req.num) : 64'(req.num);
          dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
          neg  <= req.num[63] ^ req.den[31];
        end
      end else if (busy) begin
        rem <= rem_next;
        qsh <= qsh_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= fin;
        end
      end
    end
  end

endmodule

### design/stereo_projection_jacobian_core.sv
// Stereo pinhole projection and position Jacobian, one shared multiplier and divider.
//
// Load requests (operation 0) store one of 24 camera words; the block is ready
// again right after. An evaluate request (operation 1) takes the point through
// both cameras in turn: difference to the camera position, a 3x3 rotation
// through the shared multiplier, five 64-step divisions by the depth, then six
// Jacobian entries. The 64-step divider sets the pace. A zero depth lets the
// divider answer that camera's quotients without iterating. Then sixteen results
// leave at up to one per cycle, waiting while result_stall holds a pending result,
// in the order u1, v1, u2, v2, then Jacobian rows u1, v1, u2, v2 by column x, y, z.
// Input stall stays high from an evaluate request until its last result has been
// loaded into the output register. A zero depth saturates that camera's quotients
// (a zero numerator gives zero) and raises fault on its eight results.
// focal_length, principal_u and principal_v sit at byte addresses 0, 4 and 8 and
// may be written only while idle.
module stereo_projection_jacobian_core
  import spj_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [4:0]  word_index,
  input  word_t       word_value,
  input  word_t       point_x,
  input  word_t       point_y,
  input  word_t       point_z,
  // results
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  value_index,
  output word_t       value,
  output logic        fault,
  output logic        last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_PMUL, ST_PACC, ST_QMUL, ST_QDIV, ST_QWAIT,
    ST_JMUL1, ST_JW, ST_JMUL2, ST_JENT, ST_EMIT
  } state_t;

  state_t      state;
  logic [30:0] focal;
  word_t       pu;
  word_t       pv;

  word_t       cw [NUM_WORDS];
  word_t       pt [3];
  word_t       dv [3];
  word_t       pp [3];
  word_t       qv [5];
  word_t       res [NUM_VALUES];
  word_t       wv;
  prod_t       acc;
  logic [1:0]  flt;

  logic        cam;
  logic        row;
  logic [1:0]  ii;
  logic [1:0]  jj;
  logic [2:0]  qq;
  logic [3:0]  oc;

  logic [4:0]  widx;
  word_t       word;
  mul_op_t     op_a;
  mul_op_t     op_b;
  prod_t       prod;
  prod_t       prod_sh;
  prod_t       acc_next;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [4:0]  rbase;
  logic [3:0]  jidx;
  logic        cfg_wr;

  localparam mul_op_t ONE_Q = mul_op_t'(1) <<< FRAC_BITS;

  spj_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));
  spj_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign item_stall = (state != ST_IDLE);

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_FOCAL: prdata = {1'b0, focal};
      REG_PU:    prdata = pu;
      REG_PV:    prdata = pv;
      default:   prdata = '0;
    endcase
  end

  // Camera word selection and shared multiplier operands
  always_comb begin
    rbase = cam ? 5'd15 : 5'd6;
    case (state)
      ST_DIFF:  widx = 5'(3 * cam) + 5'(jj);
      ST_PMUL:  widx = rbase + 5'(3 * jj) + 5'(ii);
      ST_JMUL1: widx = rbase + 5'(3 * jj);
      ST_JW:    widx = rbase + 5'(3 * jj) + 5'd1 + 5'(row);
      default:  widx = '0;
    endcase
    word = cw[widx];

    op_a = '0;
    op_b = '0;
    case (state)
      ST_PMUL: begin
        op_a = mul_op_t'(word);
        op_b = mul_op_t'(dv[jj]);
      end
      ST_QMUL: begin
        case (qq)
          3'd0: begin
            op_a = mul_op_t'({2'b00, focal});
            op_b = mul_op_t'(pp[1]);
          end
          3'd1: begin
            op_a = mul_op_t'({2'b00, focal});
            op_b = mul_op_t'(pp[2]);
          end
          3'd2: begin
            op_a = mul_op_t'({2'b00, focal});
            op_b = ONE_Q;
          end
          3'd3: begin
            op_a = mul_op_t'(pp[1]);
            op_b = ONE_Q;
          end
          default: begin
            op_a = mul_op_t'(pp[2]);
            op_b = ONE_Q;
          end
        endcase
      end
      ST_JMUL1: begin
        op_a = mul_op_t'(word);
        op_b = mul_op_t'(row ? qv[4] : qv[3]);
      end
      ST_JMUL2: begin
        op_a = mul_op_t'(qv[2]);
        op_b = mul_op_t'(wv);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase

    prod_sh  = prod >>> FRAC_BITS;
    acc_next = acc + prod_sh;
    jidx     = 4'(4 + 6 * cam + 3 * row + jj);

    dreq.start = (state == ST_QDIV);
    dreq.num   = prod[63:0];
    dreq.den   = pp[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      focal        <= '0;
      pu           <= '0;
      pv           <= '0;
      result_valid <= 1'b0;
      cam          <= 1'b0;
      row          <= 1'b0;
      ii           <= '0;
      jj           <= '0;
      qq           <= '0;
      oc           <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_FOCAL: focal <= pwdata[30:0];
          REG_PU:    pu    <= pwdata;
          REG_PV:    pv    <= pwdata;
          default:   ;
        endcase
      end

      // drop a delivered result; while emitting, the emit step owns the register
      if (result_valid && !result_stall && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (!operation) begin
              if (word_index < 5'(NUM_WORDS)) begin
                cw[word_index] <= word_value;
              end
            end else begin
              pt[0] <= point_x;
              pt[1] <= point_y;
              pt[2] <= point_z;
              cam   <= 1'b0;
              jj    <= '0;
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          dv[jj] <= sat_wide(prod_t'(pt[jj]) - prod_t'(word));
          if (jj == 2'd2) begin
            jj    <= '0;
            ii    <= '0;
            acc   <= '0;
            state <= ST_PMUL;
          end else begin
            jj <= jj + 2'd1;
          end
        end
        ST_PMUL: begin
          state <= ST_PACC;
        end
        ST_PACC: begin
          if (jj == 2'd2) begin
            pp[ii] <= sat_wide(acc_next);
            acc    <= '0;
            jj     <= '0;
            if (ii == 2'd2) begin
              ii    <= '0;
              qq    <= '0;
              flt[cam] <= (pp[0] == 32'sd0);
              state <= ST_QMUL;
            end else begin
              ii    <= ii + 2'd1;
              state <= ST_PMUL;
            end
          end else begin
            acc   <= acc_next;
            jj    <= jj + 2'd1;
            state <= ST_PMUL;
          end
        end
        ST_QMUL: begin
          state <= ST_QDIV;
        end
        ST_QDIV: begin
          state <= ST_QWAIT;
        end
        ST_QWAIT: begin
          if (drsp.done) begin
            qv[qq] <= drsp.quo;
            if (qq == 3'd4) begin
              res[{2'b00, cam, 1'b0}] <= sat_wide(prod_t'(pu) - prod_t'(qv[0]));
              res[{2'b00, cam, 1'b1}] <= sat_wide(prod_t'(pv) - prod_t'(qv[1]));
              row   <= 1'b0;
              jj    <= '0;
              state <= ST_JMUL1;
            end else begin
              qq    <= qq + 3'd1;
              state <= ST_QMUL;
            end
          end
        end
        ST_JMUL1: begin
          state <= ST_JW;
        end
        ST_JW: begin
          wv    <= sat_wide(prod_t'(word) - prod_sh);
          state <= ST_JMUL2;
        end
        ST_JMUL2: begin
          state <= ST_JENT;
        end
        ST_JENT: begin
          res[jidx] <= sat_wide(-prod_sh);
          state     <= ST_JMUL1;
          if (jj == 2'd2) begin
            jj <= '0;
            if (row) begin
              row <= 1'b0;
              if (cam) begin
                oc    <= '0;
                state <= ST_EMIT;
              end else begin
                cam   <= 1'b1;
                state <= ST_DIFF;
              end
            end else begin
              row <= 1'b1;
            end
          end else begin
            jj <= jj + 2'd1;
          end
        end
        ST_EMIT: begin
          // advance when the output register is free or being taken
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            value_index  <= oc;
            value        <= res[oc];
            fault        <= (oc < 4'd2 || (oc >= 4'd4 && oc < 4'd10)) ? flt[0] : flt[1];
            last         <= (oc == 4'(NUM_VALUES - 1));
            oc           <= oc + 4'd1;
            if (oc == 4'(NUM_VALUES - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
